// File: src/bpr_pkg.sv
// ----------------------------------------------------------------------------
// bpr_pkg
// Shared types and constants for the byte pattern replace block.
// ----------------------------------------------------------------------------
package bpr_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 3;

  typedef struct packed {
    logic              shift;
    logic              load;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] data;
  } bpr_cell_ctl_t;

endpackage

// File: src/bpr_cell.sv
// ----------------------------------------------------------------------------
// bpr_cell
// One window cell: holds a byte, takes its neighbor's byte on a shift or the
// incoming byte on a load at its position, and compares with its pattern byte.
// ----------------------------------------------------------------------------
module bpr_cell #(
  parameter int INDEX = 0
) (
  input  logic                  clk,
  input  bpr_pkg::bpr_cell_ctl_t ctl,
  input  logic [7:0]            right_byte,
  input  logic [7:0]            pat_byte,
  output logic [7:0]            cell_byte,
  output logic                  eq
);
  import bpr_pkg::*;

  logic hit_pos;

  assign hit_pos = ctl.load && (ctl.pos == POS_W'(INDEX));
  assign eq      = (cell_byte == pat_byte);

  always_ff @(posedge clk) begin
    if (hit_pos) begin
      cell_byte <= ctl.data;
    end else if (ctl.shift) begin
      cell_byte <= right_byte;
    end
  end

endmodule

// File: src/bpr_seq.sv
// ----------------------------------------------------------------------------
// bpr_seq
// Sequencer: steps the match loop one output word per cycle while the output
// is free, drives the cell row, and holds the output register.
// ----------------------------------------------------------------------------
module bpr_seq #(
  parameter  int PATTERN_MAX = 8,
  localparam int FW          = $clog2(PATTERN_MAX + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [FW-1:0]          len,
  input  logic [63:0]            repl_bytes,
  input  logic [PATTERN_MAX-1:0] eq,
  input  logic [7:0]             front_byte,
  output bpr_pkg::bpr_cell_ctl_t ctl,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,
  output logic                   m_tlast,
  output logic                   m_tuser
);
  import bpr_pkg::*;

  localparam int MAX_RESULTS = 8;
  localparam int NW          = $clog2(MAX_RESULTS + 1);
  localparam int KW          = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_LOOP, ST_REPL, ST_FLUSH} state_t;

  state_t        state, state_next;
  logic [FW-1:0] fill, fill_next, fill_dec, base;
  logic [NW-1:0] n, n_next, n_inc;
  logic [KW-1:0] k, k_next;
  logic          found, found_next;
  logic          last_q, last_q_next;

  logic [7:0]             repl_arr [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] mask;
  logic                   hit, out_free, cond, cont, flush_end;
  logic                   emit, shift, set_found, iter_end, clear, mark_last;
  logic                   open_in, accept, load;
  logic [7:0]             emit_byte;

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      repl_arr[i] = repl_bytes[8*i +: 8];
      mask[i]     = (FW'(i) < len);
    end
  end

  assign hit       = &(eq | ~mask);
  assign out_free  = !m_tvalid || m_tready;
  assign fill_dec  = fill - FW'(1);
  assign n_inc     = n + NW'(1);
  assign cond      = (fill >= len) &&
                     (({1'b0, n} + (NW+1)'(len)) <= (NW+1)'(MAX_RESULTS));
  assign cont      = (fill_dec >= len) &&
                     (({1'b0, n_inc} + (NW+1)'(len)) <= (NW+1)'(MAX_RESULTS));
  assign flush_end = (fill_dec == '0) || (n_inc == NW'(MAX_RESULTS));

  always_comb begin
    emit       = 1'b0;
    emit_byte  = front_byte;
    shift      = 1'b0;
    set_found  = 1'b0;
    iter_end   = 1'b0;
    clear      = 1'b0;
    mark_last  = 1'b0;
    open_in    = 1'b0;
    state_next = state;
    k_next     = k;

    unique case (state)
      ST_IDLE: begin
        open_in = 1'b1;
      end
      ST_LOOP: begin
        if (!cond) begin
          if (last_q) begin
            state_next = ST_FLUSH;
          end else begin
            open_in = 1'b1;
          end
        end else if (out_free) begin
          emit  = 1'b1;
          shift = 1'b1;
          if (hit) begin
            emit_byte = repl_arr[0];
            set_found = 1'b1;
            if (len == FW'(1)) begin
              iter_end = 1'b1;
            end else begin
              state_next = ST_REPL;
              k_next     = KW'(1);
            end
          end else begin
            iter_end = 1'b1;
          end
        end
      end
      ST_REPL: begin
        if (out_free) begin
          emit      = 1'b1;
          shift     = 1'b1;
          emit_byte = repl_arr[k];
          if ((FW'(k) + FW'(1)) == len) begin
            iter_end = 1'b1;
          end else begin
            k_next = k + KW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit  = 1'b1;
          shift = 1'b1;
          if (flush_end) begin
            mark_last = 1'b1;
            clear     = 1'b1;
            open_in   = 1'b1;
          end
        end
      end
    endcase

    if (iter_end) begin
      priority if (cont) begin
        state_next = ST_LOOP;
      end else if (!last_q) begin
        open_in = 1'b1;
      end else if (flush_end) begin
        mark_last = 1'b1;
        clear     = 1'b1;
        open_in   = 1'b1;
      end else begin
        state_next = ST_FLUSH;
      end
    end

    if (open_in) begin
      state_next = s_tvalid ? ST_LOOP : ST_IDLE;
    end
  end

  assign s_tready    = open_in;
  assign accept      = open_in && s_tvalid;
  assign base        = clear ? '0 : (shift ? fill_dec : fill);
  assign load        = accept && (base < FW'(PATTERN_MAX));
  assign fill_next   = base + FW'(load);
  assign n_next      = accept ? '0 : (emit ? n_inc : n);
  assign found_next  = clear ? 1'b0 : (found || set_found);
  assign last_q_next = accept ? s_tlast : last_q;

  assign ctl.shift = shift;
  assign ctl.load  = load;
  assign ctl.pos   = POS_W'(base);
  assign ctl.data  = s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      n        <= '0;
      k        <= '0;
      found    <= 1'b0;
      last_q   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      n      <= n_next;
      k      <= k_next;
      found  <= found_next;
      last_q <= last_q_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (emit) begin
      m_tdata <= emit_byte;
      m_tlast <= mark_last;
      m_tuser <= mark_last && (found || set_found);
    end
  end

endmodule

// File: src/byte_pattern_replace.sv
// ----------------------------------------------------------------------------
// byte_pattern_replace
// Streaming find and replace of a fixed-length byte pattern.
//
// Input words enter on the s_ side, one byte each, tlast on the final byte of
// a buffer. Output words leave on the m_ side in stream order: the original
// byte, or the replacement bytes where the pattern matched. m_tlast marks the
// final output word of a buffer and m_tuser on it reports whether any
// replacement happened in that buffer.
// Bytes wait in a row of PATTERN_MAX cells, so output lags input by up to L-1
// bytes (L = pattern length) plus the output register. Throughput is one byte
// per cycle while the output is not stalled: a non-matching byte leaves while
// the next is taken. A match sends its L replacement bytes one per cycle from
// the replacement counter, holding the input until the last one is sent. On
// the final byte the waiting bytes drain one per cycle, after a move to the
// flush state with no word sent when the window held less than a full pattern.
// A stall on m_tready holds the output register and drops s_tready as soon
// as a word must be sent. Reset clears the window fill (not the cell bytes),
// the flags and the registers (pattern length resets to 1). Write registers
// over APB at 0x00 pattern, 0x08 replacement, 0x10 length.
// ----------------------------------------------------------------------------
module byte_pattern_replace #(
  parameter int PATTERN_MAX = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,
  output logic        m_tuser    // [0] replaced_any
);
  import bpr_pkg::*;

  localparam int FW = $clog2(PATTERN_MAX + 1);

  localparam logic [1:0] REG_PATTERN = 2'd0;
  localparam logic [1:0] REG_REPL    = 2'd1;
  localparam logic [1:0] REG_LENGTH  = 2'd2;

  logic [63:0]   pattern_bytes;
  logic [63:0]   replacement_bytes;
  logic [3:0]    pattern_length;
  logic [FW-1:0] len;
  logic          wr;

  logic [7:0]             win [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] eq;
  bpr_cell_ctl_t          ctl;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes     <= '0;
      replacement_bytes <= '0;
      pattern_length    <= 4'd1;
    end else if (wr) begin
      unique case (paddr[4:3])
        REG_PATTERN: pattern_bytes     <= pwdata;
        REG_REPL:    replacement_bytes <= pwdata;
        REG_LENGTH:  pattern_length    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_PATTERN: prdata = pattern_bytes;
      REG_REPL:    prdata = replacement_bytes;
      REG_LENGTH:  prdata = {60'd0, pattern_length};
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    priority if (pattern_length == '0) begin
      len = FW'(1);
    end else if (pattern_length > 4'(PATTERN_MAX)) begin
      len = FW'(PATTERN_MAX);
    end else begin
      len = FW'(pattern_length);
    end
  end

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic [7:0] right_byte;
    if (i == PATTERN_MAX - 1) begin : g_end
      assign right_byte = win[i];
    end else begin : g_mid
      assign right_byte = win[i+1];
    end
    bpr_cell #(.INDEX(i)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .right_byte (right_byte),
      .pat_byte   (pattern_bytes[8*i +: 8]),
      .cell_byte  (win[i]),
      .eq         (eq[i])
    );
  end

  bpr_seq #(.PATTERN_MAX(PATTERN_MAX)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .len        (len),
    .repl_bytes (replacement_bytes),
    .eq         (eq),
    .front_byte (win[0]),
    .ctl        (ctl),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule
